// ----- hdl/irum_pkg.sv -----
// irum_pkg: widths, character codes, verdict codes and helper functions
// for the ident reply user matcher; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package irum_pkg;

	localparam int MAX_REPLY_BYTES = 127;
	localparam int MAX_USER_BYTES  = 8;

	localparam int BYTE_W       = 8;
	localparam int USER_W       = 64;
	localparam int LEN_W        = 4;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 64;
	localparam int VERDICT_W    = 3;
	localparam int SEEN_W       = $clog2(MAX_REPLY_BYTES + 1);
	localparam int NAME_IDX_W   = $clog2(MAX_USER_BYTES + 1);
	localparam int KW_IDX_W     = 3;
	localparam int KEYWORD_LEN  = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_USER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH = 2'd1;

	localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3a;
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
	localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_LC_A  = 8'h61;
	localparam logic [BYTE_W-1:0] CHAR_LC_Z  = 8'h7a;
	localparam logic [BYTE_W-1:0] CASE_BIT   = 8'h20;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_MATCH        = 3'd0,
		VERDICT_NAME_DIFFERS = 3'd1,
		VERDICT_NO_COLON1    = 3'd2,
		VERDICT_NO_COLON2    = 3'd3,
		VERDICT_BAD_KEYWORD  = 3'd4,
		VERDICT_NO_COLON3    = 3'd5
	} verdict_t;

	typedef enum logic [5:0] {
		PH_PORTS   = 6'b000001,
		PH_KSPACE  = 6'b000010,
		PH_KEYWORD = 6'b000100,
		PH_OSTYPE  = 6'b001000,
		PH_NSPACE  = 6'b010000,
		PH_NAME    = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [USER_W-1:0]     user;
		logic [NAME_IDX_W-1:0] limit;
	} cfg_t;

	// upper-case fold of a-z only
	function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		r = c;
		if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
			r = c & ~CASE_BIT;
		end
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] keyword_char(input logic [KW_IDX_W-1:0] i);
		logic [BYTE_W-1:0] r;
		case (i)
			3'd0:    r = 8'h55; // U
			3'd1:    r = 8'h53; // S
			3'd2:    r = 8'h45; // E
			3'd3:    r = 8'h52; // R
			3'd4:    r = 8'h49; // I
			3'd5:    r = 8'h44; // D
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/irum_reply_if.sv -----
// irum_reply_if: input channel carrying one reply byte per beat
// depends on irum_pkg
`timescale 1ns / 1ps
`default_nettype none

interface irum_reply_if;
	logic                        valid;
	logic                        ready;
	logic [irum_pkg::BYTE_W-1:0] reply_byte;
	logic                        end_of_reply;

	modport source (output valid, output reply_byte, output end_of_reply, input ready);
	modport sink   (input valid, input reply_byte, input end_of_reply, output ready);
endinterface

`default_nettype wire

// ----- hdl/irum_result_if.sv -----
// irum_result_if: output channel carrying one verdict per beat
// depends on irum_pkg
`timescale 1ns / 1ps
`default_nettype none

interface irum_result_if;
	logic                           valid;
	logic                           ready;
	logic                           user_matches;
	logic [irum_pkg::VERDICT_W-1:0] verdict;

	modport source (output valid, output user_matches, output verdict, input ready);
	modport sink   (input valid, input user_matches, input verdict, output ready);
endinterface

`default_nettype wire

// ----- hdl/ident_reply_user_matcher_top.sv -----
// ident_reply_user_matcher_top: input register, parser, result register, config
// depends on irum_pkg, irum_reply_if, irum_result_if, irum_parser
// a byte marked end_of_reply is held in the input register, then its verdict is registered in the result register
// throughput: one byte per cycle while no final byte waits behind a pending verdict
// a pending verdict stalls the input only when the next final byte is ready behind it
// reset: asynchronous, parse state to the start of a reply, config and valids to zero
`timescale 1ns / 1ps
`default_nettype none

module ident_reply_user_matcher_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	irum_reply_if.sink                           reply,
	irum_result_if.source                        result,
	input  wire logic                            cfg_we,
	input  wire logic [irum_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [irum_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [irum_pkg::USER_W-1:0] user_q;
	logic [irum_pkg::LEN_W-1:0]  len_q;
	irum_pkg::cfg_t              cfg;

	logic                        valid_s1;
	logic [irum_pkg::BYTE_W-1:0] byte_s1;
	logic                        last_s1;

	logic                        out_valid_q;
	irum_pkg::verdict_t          verdict_q;
	irum_pkg::verdict_t          verdict;

	logic                        out_free;
	logic                        adv;
	logic                        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_q <= '0;
			len_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				irum_pkg::CFG_EXPECTED_USER:   user_q <= cfg_data[irum_pkg::USER_W-1:0];
				irum_pkg::CFG_EXPECTED_LENGTH: len_q  <= cfg_data[irum_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// lengths above the buffer are clamped
	assign cfg.user  = user_q;
	assign cfg.limit = (len_q > irum_pkg::LEN_W'(irum_pkg::MAX_USER_BYTES))
	                   ? irum_pkg::NAME_IDX_W'(irum_pkg::MAX_USER_BYTES)
	                   : irum_pkg::NAME_IDX_W'(len_q);

	assign out_free    = !out_valid_q || result.ready;
	assign adv         = valid_s1 && (!last_s1 || out_free);
	assign reply.ready = !valid_s1 || adv;
	assign accept      = reply.valid && reply.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= reply.reply_byte;
			last_s1 <= reply.end_of_reply;
		end
	end

	irum_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.byte_in (byte_s1),
		.last    (last_s1),
		.cfg     (cfg),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			verdict_q <= verdict;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.verdict      = verdict_q;
	assign result.user_matches = (verdict_q == irum_pkg::VERDICT_MATCH);

	// a final byte that leaves the input register always lands a verdict
	a_final_beat_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> result.valid)
		else $error("final byte did not produce a verdict");

	// input stalls only behind a final byte blocked by a pending verdict
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!reply.ready |-> valid_s1 && last_s1 && out_valid_q && !result.ready)
		else $error("input stalled without a blocked verdict");

	// verdict codes stay within the defined set
	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (verdict_q == irum_pkg::VERDICT_MATCH
			|| verdict_q == irum_pkg::VERDICT_NAME_DIFFERS
			|| verdict_q == irum_pkg::VERDICT_NO_COLON1
			|| verdict_q == irum_pkg::VERDICT_NO_COLON2
			|| verdict_q == irum_pkg::VERDICT_BAD_KEYWORD
			|| verdict_q == irum_pkg::VERDICT_NO_COLON3))
		else $error("verdict code out of range");

	// a verdict not taken is not overwritten by the next final byte
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !(adv && last_s1))
		else $error("pending verdict overwritten");

endmodule

`default_nettype wire

// ----- hdl/irum_parser.sv -----
// irum_parser: per-byte parse state of one ident reply and its verdict
// depends on irum_pkg
`timescale 1ns / 1ps
`default_nettype none

module irum_parser (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [irum_pkg::BYTE_W-1:0] byte_in,
	input  wire logic                        last,
	input  wire irum_pkg::cfg_t              cfg,
	output irum_pkg::verdict_t               verdict
);

	irum_pkg::phase_t                    phase_q, phase_n;
	logic [irum_pkg::KW_IDX_W-1:0]       kw_idx_q, kw_idx_n;
	logic                                kw_ok_q, kw_ok_n;
	logic [irum_pkg::NAME_IDX_W-1:0]     name_idx_q, name_idx_n;
	logic                                name_diff_q, name_diff_n;
	logic [irum_pkg::SEEN_W-1:0]         seen_q, seen_n;
	logic                                ended_q, ended_n;

	logic                                take;
	logic                                term;
	logic                                is_colon;
	logic                                is_space;
	logic                                do_name;
	logic [2:0]                          name_sel;
	logic [irum_pkg::BYTE_W-1:0]         exp_char;
	logic                                name_eq;

	assign is_colon = (byte_in == irum_pkg::CHAR_COLON);
	assign is_space = (byte_in == irum_pkg::CHAR_SPACE);
	assign term     = (byte_in == irum_pkg::CHAR_CR) || (byte_in == irum_pkg::CHAR_LF)
	                  || (byte_in == irum_pkg::CHAR_NUL);
	assign take     = !ended_q
	                  && (seen_q < irum_pkg::SEEN_W'(irum_pkg::MAX_REPLY_BYTES));

	// byte lane of the expected name, taken modulo eight
	assign name_sel      = name_idx_q[2:0];
	assign exp_char      = cfg.user[8*name_sel +: 8];
	assign name_eq       = (irum_pkg::fold(byte_in) == irum_pkg::fold(exp_char));

	always_comb begin
		phase_n     = phase_q;
		kw_idx_n    = kw_idx_q;
		kw_ok_n     = kw_ok_q;
		name_idx_n  = name_idx_q;
		name_diff_n = name_diff_q;
		seen_n      = seen_q;
		ended_n     = ended_q;
		do_name     = 1'b0;
		if (take) begin
			seen_n = seen_q + 1'b1;
			if (term) begin
				ended_n = 1'b1;
			end else begin
				unique case (phase_q)
					irum_pkg::PH_PORTS: begin
						if (is_colon) phase_n = irum_pkg::PH_KSPACE;
					end
					irum_pkg::PH_KSPACE: begin
						if (is_colon) begin
							kw_ok_n = 1'b0;
							phase_n = irum_pkg::PH_OSTYPE;
						end else if (!is_space) begin
							phase_n  = irum_pkg::PH_KEYWORD;
							if (irum_pkg::fold(byte_in)
							    != irum_pkg::keyword_char(irum_pkg::KW_IDX_W'(0)))
								kw_ok_n = 1'b0;
							kw_idx_n = irum_pkg::KW_IDX_W'(1);
						end
					end
					irum_pkg::PH_KEYWORD: begin
						if (is_colon) begin
							// short keyword fails
							if (kw_idx_q < irum_pkg::KW_IDX_W'(irum_pkg::KEYWORD_LEN))
								kw_ok_n = 1'b0;
							phase_n = irum_pkg::PH_OSTYPE;
						end else if (kw_idx_q < irum_pkg::KW_IDX_W'(irum_pkg::KEYWORD_LEN)) begin
							if (irum_pkg::fold(byte_in) != irum_pkg::keyword_char(kw_idx_q))
								kw_ok_n = 1'b0;
							kw_idx_n = kw_idx_q + 1'b1;
						end
					end
					irum_pkg::PH_OSTYPE: begin
						if (is_colon) phase_n = irum_pkg::PH_NSPACE;
					end
					irum_pkg::PH_NSPACE: begin
						if (!is_space) begin
							phase_n = irum_pkg::PH_NAME;
							do_name = 1'b1;
						end
					end
					irum_pkg::PH_NAME: begin
						do_name = 1'b1;
					end
					default: begin
						phase_n = irum_pkg::PH_PORTS;
					end
				endcase
			end
		end
		if (do_name) begin
			if (name_idx_q < cfg.limit) begin
				if (!name_eq) name_diff_n = 1'b1;
				name_idx_n = name_idx_q + 1'b1;
			end else begin
				name_diff_n = 1'b1;
			end
		end
	end

	always_comb begin
		if (phase_n == irum_pkg::PH_PORTS) begin
			verdict = irum_pkg::VERDICT_NO_COLON1;
		end else if (phase_n == irum_pkg::PH_KSPACE || phase_n == irum_pkg::PH_KEYWORD) begin
			verdict = irum_pkg::VERDICT_NO_COLON2;
		end else if (!kw_ok_n) begin
			verdict = irum_pkg::VERDICT_BAD_KEYWORD;
		end else if (phase_n == irum_pkg::PH_OSTYPE) begin
			verdict = irum_pkg::VERDICT_NO_COLON3;
		end else if (name_diff_n || (name_idx_n != cfg.limit)) begin
			verdict = irum_pkg::VERDICT_NAME_DIFFERS;
		end else begin
			verdict = irum_pkg::VERDICT_MATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= irum_pkg::PH_PORTS;
			kw_idx_q    <= '0;
			kw_ok_q     <= 1'b1;
			name_idx_q  <= '0;
			name_diff_q <= 1'b0;
			seen_q      <= '0;
			ended_q     <= 1'b0;
		end else if (step) begin
			if (last) begin
				// verdict given, start over for the next reply
				phase_q     <= irum_pkg::PH_PORTS;
				kw_idx_q    <= '0;
				kw_ok_q     <= 1'b1;
				name_idx_q  <= '0;
				name_diff_q <= 1'b0;
				seen_q      <= '0;
				ended_q     <= 1'b0;
			end else begin
				phase_q     <= phase_n;
				kw_idx_q    <= kw_idx_n;
				kw_ok_q     <= kw_ok_n;
				name_idx_q  <= name_idx_n;
				name_diff_q <= name_diff_n;
				seen_q      <= seen_n;
				ended_q     <= ended_n;
			end
		end
	end

endmodule

`default_nettype wire

// ----- tb/ident_reply_user_matcher_top_tb.sv -----
// ident_reply_user_matcher_top_tb: self-checking bench for the ident reply user matcher
// drives reply bytes, predicts every verdict, stalls both channels at random
// depends on irum_pkg, irum_reply_if, irum_result_if, ident_reply_user_matcher_top
`timescale 1ns / 1ps

module ident_reply_user_matcher_top_tb;
	import irum_pkg::*;

	localparam int                   HOLD_OFF_CYCLES = 300;
	localparam int                   SETTLE_CYCLES   = 6;
	localparam int                   PHASE_BYTES     = 85;
	localparam int                   NUM_SETTINGS    = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED      = 2'd3;
	localparam logic [47:0]          KEYWORD_TEXT    = "USERID";
	localparam logic [BYTE_W-1:0]    CHAR_UC_A       = 8'h41;
	localparam logic [BYTE_W-1:0]    CHAR_UC_Z       = 8'h5a;
	localparam logic [BYTE_W-1:0]    CHAR_COMMA      = 8'h2c;

	typedef struct {
		logic [79:0] text;
		int          len;
		bit          typed;
		verdict_t    verdict;
	} reply_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	irum_reply_if  reply_ch ();
	irum_result_if result_ch ();

	ident_reply_user_matcher_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.reply     (reply_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// directed replies, parsed with registers at their reset values
	reply_row_t directed_rows [7] = '{
		'{80'h00,       1, 1'b1, VERDICT_NO_COLON1},
		'{80'hff,       1, 1'b1, VERDICT_NO_COLON1},
		'{":",          1, 1'b1, VERDICT_NO_COLON2},
		'{": :",        3, 1'b1, VERDICT_BAD_KEYWORD},
		'{":USERID:",   8, 1'b1, VERDICT_NO_COLON3},
		'{":uSeRiD::",  9, 1'b1, VERDICT_MATCH},
		'{"\n:",        2, 1'b0, VERDICT_MATCH}
	};

	// predicted parser state and register copies
	logic [USER_W-1:0] user_cfg;
	logic [LEN_W-1:0]  len_cfg;
	phase_t            parse_ph;
	int                kw_idx;
	bit                kw_good;
	int                nm_idx;
	bit                nm_bad;
	int                bytes_taken;
	bit                line_done;

	verdict_t          expected_verdicts [$];
	logic [BYTE_W-1:0] reply_buf [$];
	int                mismatches;
	int                bytes_sent;
	int                replies_sent;
	int                verdicts_seen [6];
	bit                hold_off_req;
	bit                tx_quiet;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [BYTE_W-1:0] upcase(input logic [BYTE_W-1:0] c);
		if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
			return c - 8'd32;
		end
		return c;
	endfunction

	function automatic int name_cap();
		return (len_cfg > MAX_USER_BYTES) ? MAX_USER_BYTES : int'(len_cfg);
	endfunction

	function automatic void clear_parse();
		parse_ph    = PH_PORTS;
		kw_idx      = 0;
		kw_good     = 1'b1;
		nm_idx      = 0;
		nm_bad      = 1'b0;
		bytes_taken = 0;
		line_done   = 1'b0;
	endfunction

	function automatic void take_name_byte(input logic [BYTE_W-1:0] c);
		if (nm_idx < name_cap()) begin
			if (upcase(c) != upcase(user_cfg[8*nm_idx +: 8])) begin
				nm_bad = 1'b1;
			end
			nm_idx++;
		end else begin
			nm_bad = 1'b1;
		end
	endfunction

	function automatic void advance_parse(input logic [BYTE_W-1:0] c);
		case (parse_ph)
			PH_PORTS: begin
				if (c == CHAR_COLON) parse_ph = PH_KSPACE;
			end
			PH_KSPACE: begin
				if (c == CHAR_COLON) begin
					kw_good  = 1'b0;
					parse_ph = PH_OSTYPE;
				end else if (c != CHAR_SPACE) begin
					parse_ph = PH_KEYWORD;
					if (upcase(c) != KEYWORD_TEXT[8*(KEYWORD_LEN-1) +: 8]) kw_good = 1'b0;
					kw_idx = 1;
				end
			end
			PH_KEYWORD: begin
				if (c == CHAR_COLON) begin
					if (kw_idx < KEYWORD_LEN) kw_good = 1'b0;
					parse_ph = PH_OSTYPE;
				end else if (kw_idx < KEYWORD_LEN) begin
					if (upcase(c) != KEYWORD_TEXT[8*(KEYWORD_LEN-1-kw_idx) +: 8]) begin
						kw_good = 1'b0;
					end
					kw_idx++;
				end
			end
			PH_OSTYPE: begin
				if (c == CHAR_COLON) parse_ph = PH_NSPACE;
			end
			PH_NSPACE: begin
				if (c != CHAR_SPACE) begin
					parse_ph = PH_NAME;
					take_name_byte(c);
				end
			end
			default: take_name_byte(c);
		endcase
	endfunction

	function automatic verdict_t reply_verdict();
		if (parse_ph == PH_PORTS) return VERDICT_NO_COLON1;
		if (parse_ph == PH_KSPACE || parse_ph == PH_KEYWORD) return VERDICT_NO_COLON2;
		if (!kw_good) return VERDICT_BAD_KEYWORD;
		if (parse_ph == PH_OSTYPE) return VERDICT_NO_COLON3;
		if (nm_bad || nm_idx != name_cap()) return VERDICT_NAME_DIFFERS;
		return VERDICT_MATCH;
	endfunction

	// one accepted byte; returns 1 with the verdict when the reply ends
	function automatic bit parse_reply_byte(input logic [BYTE_W-1:0] c, input bit last,
			output verdict_t v);
		v = VERDICT_MATCH;
		if (!line_done && bytes_taken < MAX_REPLY_BYTES) begin
			bytes_taken++;
			if (c == CHAR_CR || c == CHAR_LF || c == CHAR_NUL) line_done = 1'b1;
			else advance_parse(c);
		end
		if (!last) return 1'b0;
		v = reply_verdict();
		clear_parse();
		return 1'b1;
	endfunction

	// mostly no gap, sometimes a short one, rarely a long one
	function automatic int pick_gap(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [BYTE_W-1:0] filler_char();
		logic [BYTE_W-1:0] c;
		c = 8'($urandom_range(32, 126));
		if (c == CHAR_COLON) c = CHAR_COMMA;
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] rand_letter();
		if ($urandom_range(0, 1)) return CHAR_UC_A + 8'($urandom_range(0, 25));
		return CHAR_LC_A + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [BYTE_W-1:0] mixed_case(input logic [BYTE_W-1:0] c);
		bit letter;
		letter = (c >= CHAR_UC_A && c <= CHAR_UC_Z) || (c >= CHAR_LC_A && c <= CHAR_LC_Z);
		if (letter && $urandom_range(0, 1)) return c ^ CASE_BIT;
		return c;
	endfunction

	function automatic void add_filler(input int n);
		repeat (n) reply_buf.push_back(filler_char());
	endfunction

	function automatic void add_spaces();
		repeat ($urandom_range(0, 2)) reply_buf.push_back(CHAR_SPACE);
	endfunction

	// ports : USERID : ostype : name, with occasional faults in each field
	function automatic void build_wellformed();
		int r;
		int k;
		int kw_len;
		int bad_pos;
		int nm_len;
		int cap;
		logic [BYTE_W-1:0] c;
		add_filler($urandom_range(0, 6));
		if ($urandom_range(0, 19) == 0) begin
			add_filler($urandom_range(1, 4));
			return;
		end
		reply_buf.push_back(CHAR_COLON);
		add_spaces();
		r = $urandom_range(0, 19);
		kw_len = (r == 0) ? $urandom_range(0, KEYWORD_LEN - 1) : KEYWORD_LEN;
		bad_pos = (r == 1) ? $urandom_range(0, KEYWORD_LEN - 1) : -1;
		for (k = 0; k < kw_len; k++) begin
			c = (k == bad_pos) ? rand_letter() : KEYWORD_TEXT[8*(KEYWORD_LEN-1-k) +: 8];
			reply_buf.push_back(mixed_case(c));
		end
		if (r == 2) add_filler($urandom_range(1, 3));
		if ($urandom_range(0, 19) == 0) return;
		reply_buf.push_back(CHAR_COLON);
		// a long os type can push the name past the byte limit
		if ($urandom_range(0, 29) == 0) add_filler($urandom_range(100, 140));
		else add_filler($urandom_range(0, 5));
		if ($urandom_range(0, 19) == 0) return;
		reply_buf.push_back(CHAR_COLON);
		add_spaces();
		cap = name_cap();
		r = $urandom_range(0, 9);
		nm_len = (r == 0 && cap > 0) ? cap - 1 : cap;
		bad_pos = (r == 1 && cap > 0) ? $urandom_range(0, cap - 1) : -1;
		for (k = 0; k < nm_len; k++) begin
			c = (k == bad_pos) ? rand_letter() : user_cfg[8*k +: 8];
			reply_buf.push_back(mixed_case(c));
		end
		if (r == 2) add_filler($urandom_range(1, 2));
		if (r == 3) reply_buf.push_back(CHAR_COLON);
		if ($urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 2))
				0:       reply_buf.push_back(CHAR_CR);
				1:       reply_buf.push_back(CHAR_LF);
				default: reply_buf.push_back(CHAR_NUL);
			endcase
			repeat ($urandom_range(0, 3)) reply_buf.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	function automatic void build_noise();
		repeat ($urandom_range(1, 12)) begin
			case ($urandom_range(0, 3))
				0:       reply_buf.push_back(CHAR_COLON);
				1:       reply_buf.push_back(CHAR_SPACE);
				default: reply_buf.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	// called right after a rising edge; returns right after the edge that takes the beat
	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit last, input bit typed,
			input verdict_t typed_v);
		int gap;
		verdict_t v;
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			reply_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		reply_ch.valid        <= 1'b1;
		reply_ch.reply_byte   <= b;
		reply_ch.end_of_reply <= last;
		do @(negedge clk); while (reply_ch.ready !== 1'b1);
		@(posedge clk);
		if (parse_reply_byte(b, last, v)) begin
			expected_verdicts.push_back(typed ? typed_v : v);
			replies_sent++;
		end
		bytes_sent++;
	endtask

	task automatic send_reply_buf();
		int i;
		tx_quiet = ($urandom_range(0, 3) == 0);
		for (i = 0; i < reply_buf.size(); i++) begin
			send_byte(reply_buf[i], i == reply_buf.size() - 1, 1'b0, VERDICT_MATCH);
		end
		reply_buf.delete();
	endtask

	task automatic drain_verdicts();
		reply_ch.valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [USER_W-1:0] user, input logic [CFG_DATA_W-1:0] len_word);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_EXPECTED_USER;
		cfg_data  <= user;
		@(posedge clk);
		user_cfg = user;
		cfg_index <= CFG_EXPECTED_LENGTH;
		cfg_data  <= len_word;
		@(posedge clk);
		len_cfg = len_word[LEN_W-1:0];
		// an index with no register behind it changes nothing
		cfg_index <= CFG_UNUSED;
		cfg_data  <= {$urandom, $urandom};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [USER_W-1:0] letter_name();
		logic [USER_W-1:0] u;
		int k;
		for (k = 0; k < MAX_USER_BYTES; k++) u[8*k +: 8] = rand_letter();
		return u;
	endfunction

	// receiver: random stalls, stretches of steady ready, and one long hold-off
	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if ($urandom_range(0, 15) == 0) begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end else begin
				stall = pick_gap(1'b0);
				if (stall > 0) begin
					result_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// outputs are sampled on the falling edge, ahead of the edge that takes the beat
	always @(negedge clk) begin
		verdict_t want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (expected_verdicts.size() == 0) begin
				$error("verdict beat with nothing expected: verdict %0d", result_ch.verdict);
				mismatches++;
			end else begin
				want = expected_verdicts.pop_front();
				if (result_ch.verdict !== want) begin
					$error("verdict: expected %0d, actual %0d", want, result_ch.verdict);
					mismatches++;
				end
				if (result_ch.user_matches !== (want == VERDICT_MATCH)) begin
					$error("user_matches: expected %0d, actual %0d",
						want == VERDICT_MATCH, result_ch.user_matches);
					mismatches++;
				end
				verdicts_seen[want]++;
			end
		end
	end

	initial begin
		logic [USER_W-1:0]     user;
		logic [CFG_DATA_W-1:0] len_word;
		int start;
		int p;
		int r;
		int i;
		arst_n = 1'b0;
		mismatches = 0;
		bytes_sent = 0;
		replies_sent = 0;
		hold_off_req = 1'b0;
		tx_quiet = 1'b0;
		foreach (verdicts_seen[i]) verdicts_seen[i] = 0;
		user_cfg = '0;
		len_cfg = '0;
		clear_parse();
		reply_ch.valid        <= 1'b0;
		reply_ch.reply_byte   <= '0;
		reply_ch.end_of_reply <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			for (i = 0; i < directed_rows[r].len; i++) begin
				send_byte(directed_rows[r].text[8*(directed_rows[r].len-1-i) +: 8],
					i == directed_rows[r].len - 1, directed_rows[r].typed,
					directed_rows[r].verdict);
			end
		end
		drain_verdicts();

		for (p = 0; p < NUM_SETTINGS; p++) begin
			user = letter_name();
			len_word = {$urandom, $urandom};
			case (p)
				0: len_word[LEN_W-1:0] = LEN_W'(MAX_USER_BYTES);
				1: len_word[LEN_W-1:0] = '0;
				2: len_word[LEN_W-1:0] = '1;
				3: begin
					user = '1;
					len_word[LEN_W-1:0] = LEN_W'($urandom_range(1, MAX_USER_BYTES));
				end
				4: begin
					// a zero byte inside the name can never be matched
					user[8*$urandom_range(0, MAX_USER_BYTES - 1) +: 8] = CHAR_NUL;
					len_word[LEN_W-1:0] = LEN_W'(MAX_USER_BYTES);
				end
				5: user = {$urandom, $urandom};
				6: len_word[LEN_W-1:0] = LEN_W'($urandom_range(1, 3));
				default: begin
					user = '0;
					len_word[LEN_W-1:0] = LEN_W'(1);
				end
			endcase
			if (p < 3) len_word[CFG_DATA_W-1:LEN_W] = '0;
			apply_setting(user, len_word);
			if (p == 2) hold_off_req = 1'b1;
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES) begin
				r = $urandom_range(0, 99);
				if (r < 2) begin
					add_filler($urandom_range(MAX_REPLY_BYTES, MAX_REPLY_BYTES + 8));
					reply_buf.push_back(CHAR_COLON);
				end else if (r < 77) begin
					build_wellformed();
				end else begin
					build_noise();
				end
				send_reply_buf();
			end
			drain_verdicts();
		end

		$display("%0d replies in %0d bytes over %0d register settings, one long result stall",
			replies_sent, bytes_sent, NUM_SETTINGS);
		$display("verdicts: match %0d, name %0d, colon1 %0d, colon2 %0d, keyword %0d, colon3 %0d",
			verdicts_seen[VERDICT_MATCH], verdicts_seen[VERDICT_NAME_DIFFERS],
			verdicts_seen[VERDICT_NO_COLON1], verdicts_seen[VERDICT_NO_COLON2],
			verdicts_seen[VERDICT_BAD_KEYWORD], verdicts_seen[VERDICT_NO_COLON3]);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
